### hw/rtl/apms_pkg.sv
// Package for the audio power/mute sequencer: mode and step codes, pin set,
// register indexes and reset values. No dependencies.
package apms_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_USB  = 2'd1,
    MODE_ANA  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STEP_START = 2'd0,
    STEP_WAIT1 = 2'd1,
    STEP_WAIT2 = 2'd2,
    STEP_DONE  = 2'd3
  } step_e;

  // Config register indexes
  localparam logic [1:0] CFG_STEP_DELAY    = 2'd0;
  localparam logic [1:0] CFG_BLINK_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_POLL_INTERVAL = 2'd2;

  localparam int unsigned DelayW  = 8;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned PollW   = 4;
  localparam int unsigned WaitW   = DelayW + 1;
  localparam int unsigned BlinkW  = PeriodW + 1;
  localparam int unsigned CfgW    = PeriodW;

  localparam logic [DelayW-1:0]  StepDelayRst    = DelayW'(10);
  localparam logic [PeriodW-1:0] BlinkPeriodRst  = PeriodW'(100);
  localparam logic [PollW-1:0]   PollIntervalRst = PollW'(2);
  localparam logic [BlinkW-1:0]  BlinkMax        = '1;

  typedef struct packed {
    logic pwr_n;
    logic mute;
    logic relay;
    logic sel_ana;
    logic led_hb;
    logic led_off;
    logic led_ana;
  } pins_t;

  localparam pins_t PinsRst = '{
    pwr_n: 1'b0, mute: 1'b1, relay: 1'b0, sel_ana: 1'b0,
    led_hb: 1'b1, led_off: 1'b1, led_ana: 1'b1
  };

endpackage

### hw/rtl/audio_power_mute_sequencer.sv
// Top level of the audio power/mute sequencer: input stage, tick/sequence
// update and result registers. Depends on apms_pkg.
//
//  channel | signals                                   | dir | beat
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid_i/in_ready_o, *_switch_i          | in  | one 10 ms tick
//  out     | out_valid_o/out_ready_i, pins, mode, step  | out | pin/mode/step after tick
//  cfg     | cfg_valid_i/cfg_ready_o, index, data       | in  | one register write
//
// One beat per cycle sustained while the output is not stalled. A tick is held
// in the input register, then the update logic writes the state, which is also
// the result register.
// Reset is asynchronous, active low; it loads the register defaults and pins.
// A stall on the output holds the result and the tick in the input register;
// input is refused only when both are full. Config writes are always taken.
module audio_power_mute_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       power_switch_i,
  input  logic       source_switch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       power_enable_n_o,
  output logic       mute_o,
  output logic       mute_relay_o,
  output logic       select_analog_o,
  output logic       led_heartbeat_o,
  output logic       led_off_mode_o,
  output logic       led_analog_mode_o,
  output logic [1:0] mode_o,
  output logic [1:0] step_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [apms_pkg::CfgW-1:0] cfg_data_i
);

  // Config registers
  logic [apms_pkg::DelayW-1:0]  step_delay_q;
  logic [apms_pkg::PeriodW-1:0] blink_period_q;
  logic [apms_pkg::PollW-1:0]   poll_interval_q;

  // Input stage
  logic in_valid_q, pwr_q, src_q;

  // Sequencer state; pins/mode/step double as the result register
  apms_pkg::mode_e mode_q, mode_d;
  apms_pkg::step_e step_q, step_d;
  apms_pkg::pins_t pins_q, pins_d;
  logic [apms_pkg::WaitW-1:0]  wait_q, wait_d;
  logic [apms_pkg::PollW-1:0]  poll_q, poll_d;
  logic [apms_pkg::BlinkW-1:0] blink_q, blink_d;
  logic                        phase_q, phase_d;
  logic                        out_valid_q;

  logic                        upd;       // stage 2 fires
  logic [apms_pkg::PollW-1:0]  limit;
  logic [apms_pkg::WaitW-1:0]  wait_dec, wait_load;
  logic [apms_pkg::BlinkW-1:0] blink_inc;
  logic                        eval;
  apms_pkg::mode_e             dec_mode;

  assign cfg_ready_o = 1'b1;
  assign upd         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q    <= apms_pkg::StepDelayRst;
      blink_period_q  <= apms_pkg::BlinkPeriodRst;
      poll_interval_q <= apms_pkg::PollIntervalRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        apms_pkg::CFG_STEP_DELAY:    step_delay_q    <= cfg_data_i[apms_pkg::DelayW-1:0];
        apms_pkg::CFG_BLINK_PERIOD:  blink_period_q  <= cfg_data_i[apms_pkg::PeriodW-1:0];
        apms_pkg::CFG_POLL_INTERVAL: poll_interval_q <= cfg_data_i[apms_pkg::PollW-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload holds while the stage is full
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pwr_q <= power_switch_i;
      src_q <= source_switch_i;
    end
  end

  // Per-tick counters; poll interval zero counts as one
  assign limit     = (poll_interval_q == '0) ? apms_pkg::PollW'(1) : poll_interval_q;
  assign blink_inc = (blink_q == apms_pkg::BlinkMax) ? blink_q : blink_q + 1'b1;
  assign wait_dec  = (wait_q != '0) ? wait_q - 1'b1 : wait_q;
  // poll_q never exceeds 14, so the increment fits
  assign eval      = (poll_q + 1'b1) >= limit;
  assign wait_load = {1'b0, step_delay_q} + 1'b1;

  always_comb begin
    case ({pwr_q, src_q})
      2'b01:   dec_mode = apms_pkg::MODE_OFF;
      2'b11:   dec_mode = apms_pkg::MODE_USB;
      2'b10:   dec_mode = apms_pkg::MODE_ANA;
      default: dec_mode = apms_pkg::MODE_NONE;
    endcase
  end

  // Next state for one tick
  always_comb begin
    blink_d = blink_inc;
    wait_d  = wait_dec;
    poll_d  = eval ? '0 : poll_q + 1'b1;
    phase_d = phase_q;
    pins_d  = pins_q;
    mode_d  = mode_q;
    step_d  = step_q;

    if (eval) begin
      // heartbeat
      if (blink_inc > apms_pkg::BlinkW'(blink_period_q)) begin
        phase_d       = !phase_q;
        pins_d.led_hb = phase_q;   // LED is inverse of new phase
        blink_d       = '0;
      end

      // mode LEDs; mode none leaves them alone
      case (dec_mode)
        apms_pkg::MODE_OFF: begin
          pins_d.led_off = 1'b1;
          pins_d.led_ana = 1'b0;
        end
        apms_pkg::MODE_USB: begin
          pins_d.led_off = 1'b0;
          pins_d.led_ana = 1'b0;
        end
        apms_pkg::MODE_ANA: begin
          pins_d.led_off = 1'b0;
          pins_d.led_ana = 1'b1;
        end
        default: ;
      endcase

      // mode change restarts the sequence
      if (dec_mode != mode_q) begin
        mode_d = dec_mode;
        step_d = apms_pkg::STEP_START;
      end

      case (mode_d)
        apms_pkg::MODE_OFF: begin
          if (step_d == apms_pkg::STEP_START) begin
            pins_d.mute  = 1'b1;
            pins_d.relay = 1'b0;
            wait_d       = wait_load;
            step_d       = apms_pkg::STEP_WAIT1;
          end else if (step_d == apms_pkg::STEP_WAIT1 && wait_dec == '0) begin
            pins_d.pwr_n = 1'b1;
            step_d       = apms_pkg::STEP_DONE;
          end
        end
        apms_pkg::MODE_USB, apms_pkg::MODE_ANA: begin
          if (step_d == apms_pkg::STEP_START) begin
            pins_d.relay = 1'b1;
            pins_d.mute  = 1'b1;
            wait_d       = wait_load;
            step_d       = apms_pkg::STEP_WAIT1;
          end else if (step_d == apms_pkg::STEP_WAIT1 && wait_dec == '0) begin
            pins_d.sel_ana = (mode_d == apms_pkg::MODE_ANA);
            pins_d.pwr_n   = 1'b0;
            wait_d         = wait_load;
            step_d         = apms_pkg::STEP_WAIT2;
          end else if (step_d == apms_pkg::STEP_WAIT2 && wait_dec == '0) begin
            pins_d.mute = 1'b0;
            step_d      = apms_pkg::STEP_DONE;
          end
        end
        default: ;  // mode none: pins and step hold
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= apms_pkg::MODE_NONE;
      step_q  <= apms_pkg::STEP_START;
      pins_q  <= apms_pkg::PinsRst;
      wait_q  <= '0;
      poll_q  <= '0;
      blink_q <= '0;
      phase_q <= 1'b0;
    end else if (upd) begin
      mode_q  <= mode_d;
      step_q  <= step_d;
      pins_q  <= pins_d;
      wait_q  <= wait_d;
      poll_q  <= poll_d;
      blink_q <= blink_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // State only moves on upd, so a pending result holds
  always_comb begin
    out_valid_o       = out_valid_q;
    power_enable_n_o  = pins_q.pwr_n;
    mute_o            = pins_q.mute;
    mute_relay_o      = pins_q.relay;
    select_analog_o   = pins_q.sel_ana;
    led_heartbeat_o   = pins_q.led_hb;
    led_off_mode_o    = pins_q.led_off;
    led_analog_mode_o = pins_q.led_ana;
    mode_o            = mode_q;
    step_o            = step_q;
  end

endmodule

### hw/rtl/apms_checker.sv
// Port-level checker for the audio power/mute sequencer, bound to the top.
// Depends on apms_pkg and audio_power_mute_sequencer.
module apms_port_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       power_enable_n_o,
  input logic       mute_o,
  input logic       mute_relay_o,
  input logic       select_analog_o,
  input logic       led_off_mode_o,
  input logic       led_analog_mode_o,
  input logic [1:0] mode_o,
  input logic [1:0] step_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mode_o) && $stable(step_o)
      && $stable(mute_o) && $stable(power_enable_n_o))
    else $error("result changed under stall");

  // mode LEDs agree with the decoded mode
  a_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o != apms_pkg::MODE_NONE |->
      led_off_mode_o == (mode_o == apms_pkg::MODE_OFF) &&
      led_analog_mode_o == (mode_o == apms_pkg::MODE_ANA))
    else $error("mode LEDs disagree with mode");

  // an active mode has always left its start step; power-off skips step 2
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o != apms_pkg::MODE_NONE |->
      step_o != apms_pkg::STEP_START &&
      !(mode_o == apms_pkg::MODE_OFF && step_o == apms_pkg::STEP_WAIT2))
    else $error("illegal step for mode");

  // finished input sequence: powered, relay on, unmuted, right select
  a_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_o == apms_pkg::STEP_DONE &&
      (mode_o == apms_pkg::MODE_USB || mode_o == apms_pkg::MODE_ANA) |->
      !mute_o && mute_relay_o && !power_enable_n_o &&
      select_analog_o == (mode_o == apms_pkg::MODE_ANA))
    else $error("input sequence ended in wrong pin state");

  // finished power-off: muted, relay off, supply off
  a_off_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_o == apms_pkg::STEP_DONE && mode_o == apms_pkg::MODE_OFF |->
      mute_o && !mute_relay_o && power_enable_n_o)
    else $error("power-off sequence ended in wrong pin state");

endmodule

bind audio_power_mute_sequencer apms_port_sva u_apms_port_sva (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .power_enable_n_o  (power_enable_n_o),
  .mute_o            (mute_o),
  .mute_relay_o      (mute_relay_o),
  .select_analog_o   (select_analog_o),
  .led_off_mode_o    (led_off_mode_o),
  .led_analog_mode_o (led_analog_mode_o),
  .mode_o            (mode_o),
  .step_o            (step_o)
);
